/* hdl/bloom_filter_murmur2_defines.svh */
// assertion macros for the bloom filter rtl, used by bfm_front
`ifndef BLOOM_FILTER_MURMUR2_DEFINES_SVH
`define BLOOM_FILTER_MURMUR2_DEFINES_SVH

// same-cycle implication, checked on every clock edge out of reset
`define BFM_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("bloom filter check failed");

// next-cycle implication
`define BFM_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("bloom filter check failed");

`endif

/* hdl/bfm_pkg.sv */
package bfm_pkg;

	// operation codes of the mode and op_done fields
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_QUERY  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// murmur2 constants
	localparam logic [31:0] MUR_M      = 32'h5bd1e995;
	localparam logic [31:0] SEED_RESET = 32'h52ed88ff;

	// job length field covers the largest word buffer
	localparam int LEN_W = 11;

	// register map
	localparam logic [1:0] REG_SEED_ADDR = 2'd0;

	// job handed from the front to the back
	typedef struct packed {
		op_t              op;
		logic [LEN_W-1:0] len;
		logic             trunc;
		logic             bank;
	} job_t;

	// back-to-front status
	typedef struct packed {
		logic init_busy;
		logic word_done;
	} back_status_t;

endpackage

/* hdl/bfm_ram.sv */
module bfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/bfm_queue.sv */
module bfm_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bfm_pkg::job_t din,
	input  logic          pop,
	output bfm_pkg::job_t dout,
	output logic          full,
	output logic          empty
);

	bfm_pkg::job_t ent_q [2];
	logic          rd_q;
	logic          wr_q;
	logic [1:0]    cnt_q;

	assign dout  = ent_q[rd_q];
	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hdl/bfm_front.sv */
`include "bloom_filter_murmur2_defines.svh"

module bfm_front #(
	parameter int MAX_WORD_LEN = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    mode,
	input  logic [7:0]                    data_byte,
	input  logic                          last,
	input  bfm_pkg::back_status_t         status,
	input  logic                          q_full,
	output logic                          q_push,
	output bfm_pkg::job_t                 q_din,
	output logic                          buf_we,
	output logic [$clog2(MAX_WORD_LEN):0] buf_waddr,
	output logic [7:0]                    buf_wdata
);

	localparam int BW = $clog2(MAX_WORD_LEN);
	localparam int LW = $clog2(MAX_WORD_LEN + 1);

	logic [LW-1:0] len_q;
	logic          ovf_q;
	logic          bank_q;
	logic [1:0]    word_jobs_q;

	logic          acc;
	logic          is_word;
	logic          is_clear;
	logic          has_room;
	logic [LW-1:0] new_len;
	logic          new_ovf;
	logic          job_inc;

	assign is_word  = (mode == bfm_pkg::OP_INSERT) || (mode == bfm_pkg::OP_QUERY);
	assign is_clear = (mode == bfm_pkg::OP_CLEAR);
	// a word needs a free buffer bank, every job needs a queue slot
	assign in_stall = status.init_busy || ((is_word || is_clear) && q_full)
		|| (is_word && word_jobs_q == 2'd2);
	assign acc      = in_valid && !in_stall;

	assign has_room = (len_q < LW'(MAX_WORD_LEN));
	assign new_len  = has_room ? len_q + LW'(1) : len_q;
	assign new_ovf  = ovf_q || !has_room;

	assign buf_we    = acc && is_word && has_room;
	assign buf_waddr = {bank_q, len_q[BW-1:0]};
	assign buf_wdata = data_byte;

	assign job_inc = acc && is_word && last;
	assign q_push  = job_inc || (acc && is_clear);

	always_comb begin
		q_din.op    = bfm_pkg::op_t'(mode);
		q_din.len   = is_word ? bfm_pkg::LEN_W'(new_len) : '0;
		q_din.trunc = is_word && new_ovf;
		q_din.bank  = bank_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			ovf_q       <= 1'b0;
			bank_q      <= 1'b0;
			word_jobs_q <= 2'd0;
		end else begin
			if (acc && is_clear) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end else if (acc && is_word) begin
				if (last) begin
					len_q  <= '0;
					ovf_q  <= 1'b0;
					bank_q <= ~bank_q;
				end else begin
					len_q <= new_len;
					ovf_q <= new_ovf;
				end
			end
			case ({job_inc, status.word_done})
				2'b10:   word_jobs_q <= word_jobs_q + 2'd1;
				2'b01:   word_jobs_q <= word_jobs_q - 2'd1;
				default: word_jobs_q <= word_jobs_q;
			endcase
		end
	end

	`BFM_ASSERT_NOW(a_jobs_bound, 1'b1, word_jobs_q != 2'd3)
	`BFM_ASSERT_NOW(a_no_push_full, q_push, !q_full)
	`BFM_ASSERT_NOW(a_no_accept_init, status.init_busy, !acc)

endmodule

/* hdl/bfm_back.sv */
module bfm_back #(
	parameter int BIT_COUNT    = 65536,
	parameter int HASH_COUNT   = 4,
	parameter int MAX_WORD_LEN = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [31:0]                   seed,
	input  logic                          q_empty,
	input  bfm_pkg::job_t                 q_dout,
	output logic                          q_pop,
	output bfm_pkg::back_status_t         status,
	output logic                          buf_re,
	output logic [$clog2(MAX_WORD_LEN):0] buf_raddr,
	input  logic [7:0]                    buf_rdata,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          present,
	output logic                          truncated,
	output logic [1:0]                    op_done
);

	localparam int BW = $clog2(MAX_WORD_LEN);
	localparam int LW = $clog2(MAX_WORD_LEN + 1);
	localparam int AW = $clog2(BIT_COUNT);
	localparam int PW = $clog2(HASH_COUNT + 1);
	// floor(2^32 / BIT_COUNT), the quotient estimate is at most one low
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BIT_COUNT));
	localparam logic [31:0] NMOD  = 32'(BIT_COUNT);

	typedef enum logic [4:0] {
		S_IDLE, S_SWEEP, S_SEED, S_FETCH, S_LOADB, S_KMUL1, S_KMIX, S_KMUL2,
		S_HMUL, S_HXOR, S_TAILX, S_TAILMUL, S_FIN1, S_FMUL, S_FIN2, S_MOD,
		S_MODR, S_MODFIX, S_BITOP, S_BITCHK, S_NEXT, S_DONE
	} state_t;

	state_t           state_q;
	logic             init_q;
	bfm_pkg::op_t     op_q;
	logic [LW-1:0]    len_q;
	logic             trunc_q;
	logic             bank_q;
	logic [LW-1:0]    pos_q;
	logic [31:0]      h_q;
	logic [31:0]      k_q;
	logic [31:0]      quo_q;
	logic [31:0]      red_q;
	logic [AW-1:0]    rem_q;
	logic [AW-1:0]    sweep_q;
	logic [PW-1:0]    pass_q;
	logic             hit_q;
	logic             out_valid_q;
	logic             present_q;
	logic             trunc_out_q;
	logic [1:0]       op_out_q;

	logic             out_free;
	logic [31:0]      mul_src;
	logic [31:0]      prod;
	logic [63:0]      recip_prod;
	logic [31:0]      quo_mul;
	logic [31:0]      red_fix;
	logic [LW-1:0]    pos_n;
	logic [1:0]       lane;
	logic             bit_we;
	logic [AW-1:0]    bit_addr;
	logic             bit_re;
	logic             bit_rdata;

	assign out_free = !out_valid_q || !out_stall;

	// one shared multiplier by the murmur constant
	assign mul_src = (state_q == S_KMUL1 || state_q == S_KMUL2) ? k_q : h_q;
	assign prod    = mul_src * bfm_pkg::MUR_M;

	// remainder by reciprocal multiply, then one correction step
	assign recip_prod = {32'd0, h_q} * {32'd0, RECIP};
	assign quo_mul    = quo_q * NMOD;
	assign red_fix    = (red_q >= NMOD) ? red_q - NMOD : red_q;

	assign pos_n = pos_q + LW'(1);
	assign lane  = pos_q[1:0];

	assign q_pop            = (state_q == S_IDLE) && !q_empty;
	assign status.init_busy = init_q;
	assign status.word_done = (state_q == S_DONE) && out_free && (op_q != bfm_pkg::OP_CLEAR);

	assign buf_re    = (state_q == S_FETCH);
	assign buf_raddr = {bank_q, pos_q[BW-1:0]};

	assign bit_we   = (state_q == S_SWEEP) || (state_q == S_BITOP && op_q == bfm_pkg::OP_INSERT);
	assign bit_addr = (state_q == S_SWEEP) ? sweep_q : rem_q;
	assign bit_re   = (state_q == S_BITOP) && (op_q == bfm_pkg::OP_QUERY);

	bfm_ram #(
		.WIDTH (1),
		.DEPTH (2**AW)
	) u_bits (
		.clk   (clk),
		.we    (bit_we),
		.waddr (bit_addr),
		.wdata (state_q == S_BITOP),
		.re    (bit_re),
		.raddr (bit_addr),
		.rdata (bit_rdata)
	);

	assign out_valid = out_valid_q;
	assign present   = present_q;
	assign truncated = trunc_out_q;
	assign op_done   = op_out_q;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q    <= q_dout.op;
				len_q   <= q_dout.len[LW-1:0];
				trunc_q <= q_dout.trunc;
				bank_q  <= q_dout.bank;
				hit_q   <= 1'b1;
				pass_q  <= '0;
				h_q     <= seed;
			end
			S_SEED: begin
				h_q   <= h_q ^ 32'(len_q);
				pos_q <= '0;
			end
			S_LOADB: begin
				k_q   <= (lane == 2'd0) ? {24'd0, buf_rdata}
					: k_q | (32'(buf_rdata) << {lane, 3'b000});
				pos_q <= pos_n;
			end
			S_KMUL1, S_KMUL2: k_q <= prod;
			S_KMIX:           k_q <= k_q ^ (k_q >> 24);
			S_HMUL, S_TAILMUL, S_FMUL: h_q <= prod;
			S_HXOR, S_TAILX:  h_q <= h_q ^ k_q;
			S_FIN1: h_q <= h_q ^ (h_q >> 13);
			S_FIN2: h_q <= h_q ^ (h_q >> 15);
			S_MOD:    quo_q <= recip_prod[63:32];
			S_MODR:   red_q <= h_q - quo_mul;
			S_MODFIX: rem_q <= red_fix[AW-1:0];
			S_BITCHK: hit_q <= hit_q & bit_rdata;
			S_NEXT: begin
				pass_q <= pass_q + PW'(1);
				h_q    <= h_q ^ 32'(len_q);
				pos_q  <= '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			init_q      <= 1'b1;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
			present_q   <= 1'b0;
			trunc_out_q <= 1'b0;
			op_out_q    <= 2'd0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						sweep_q <= '0;
						state_q <= (q_dout.op == bfm_pkg::OP_CLEAR) ? S_SWEEP : S_SEED;
					end
				end
				S_SWEEP: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == AW'(BIT_COUNT - 1)) begin
						init_q  <= 1'b0;
						state_q <= init_q ? S_IDLE : S_DONE;
					end
				end
				S_SEED:  state_q <= S_FETCH;
				S_FETCH: state_q <= S_LOADB;
				S_LOADB: begin
					if (lane == 2'd3) begin
						state_q <= S_KMUL1;
					end else if (pos_n == len_q) begin
						state_q <= S_TAILX;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_KMUL1: state_q <= S_KMIX;
				S_KMIX:  state_q <= S_KMUL2;
				S_KMUL2: state_q <= S_HMUL;
				S_HMUL:  state_q <= S_HXOR;
				S_HXOR:  state_q <= (pos_q == len_q) ? S_FIN1 : S_FETCH;
				S_TAILX:   state_q <= S_TAILMUL;
				S_TAILMUL: state_q <= S_FIN1;
				S_FIN1: state_q <= S_FMUL;
				S_FMUL: state_q <= S_FIN2;
				S_FIN2: state_q <= S_MOD;
				S_MOD:    state_q <= S_MODR;
				S_MODR:   state_q <= S_MODFIX;
				S_MODFIX: state_q <= S_BITOP;
				S_BITOP:  state_q <= (op_q == bfm_pkg::OP_QUERY) ? S_BITCHK : S_NEXT;
				S_BITCHK: state_q <= S_NEXT;
				S_NEXT: begin
					state_q <= (pass_q == PW'(HASH_COUNT - 1)) ? S_DONE : S_FETCH;
				end
				S_DONE: begin
					if (out_free) begin
						present_q   <= (op_q == bfm_pkg::OP_QUERY) && hit_q;
						trunc_out_q <= (op_q != bfm_pkg::OP_CLEAR) && trunc_q;
						op_out_q    <= op_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hdl/bloom_filter_murmur2.sv */
// bloom filter over byte-string words, hashed with chained murmur2
// input channel (in_valid/in_stall): one beat per word byte with mode,
//   data_byte and last; mode insert/query bytes are buffered, last ends a
//   word, clear wipes the filter, mode three is dropped with no result
// output channel (out_valid/out_stall): one beat per finished word or
//   clear, carrying present, truncated and op_done
// config: apb-style port, initial_seed at byte address 0, pready always high
// hashing: pickup, seeding, then HASH_COUNT passes per word, each loading
//   the bytes, mixing full blocks, folding in a partial block, finalizing,
//   reducing modulo BIT_COUNT and writing the bit (reading it for a query),
//   then the result; a clear writes one filter bit per cycle
// throughput: the front takes one byte per cycle, unless in_stall is high,
//   into a two-bank word buffer while the back hashes the previous word;
//   a two-entry job queue sits between them
// reset: the filter memory is wiped by a sweep over every bit, during which
//   in_stall is held high; config writes are taken as ever
// when the receiver stalls the result stays in the output register, the
//   back finishes its current job and then waits, and the front keeps
//   taking bytes until the queue or both buffer banks fill up
module bloom_filter_murmur2 #(
	parameter int BIT_COUNT    = 65536,
	parameter int HASH_COUNT   = 4,
	parameter int MAX_WORD_LEN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input beats
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  data_byte,
	input  logic        last,
	// result beats
	output logic        out_valid,
	input  logic        out_stall,
	output logic        present,
	output logic        truncated,
	output logic [1:0]  op_done
);

	localparam int BW = $clog2(MAX_WORD_LEN);

	logic [31:0] seed_q;

	bfm_pkg::back_status_t status;
	bfm_pkg::job_t         q_din;
	bfm_pkg::job_t         q_dout;
	logic                  q_push;
	logic                  q_pop;
	logic                  q_full;
	logic                  q_empty;
	logic                  buf_we;
	logic [BW:0]           buf_waddr;
	logic [7:0]            buf_wdata;
	logic                  buf_re;
	logic [BW:0]           buf_raddr;
	logic [7:0]            buf_rdata;

	// single register, so every write lands in the seed
	assign pready = 1'b1;
	assign prdata = (paddr == bfm_pkg::REG_SEED_ADDR) ? seed_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= bfm_pkg::SEED_RESET;
		end else if (psel && penable && pwrite && pready) begin
			seed_q <= pwdata;
		end
	end

	// byte intake and job classification
	bfm_front #(
		.MAX_WORD_LEN (MAX_WORD_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.data_byte (data_byte),
		.last      (last),
		.status    (status),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_din     (q_din),
		.buf_we    (buf_we),
		.buf_waddr (buf_waddr),
		.buf_wdata (buf_wdata)
	);

	// two banks of word bytes, written by the front, read by the back
	bfm_ram #(
		.WIDTH (8),
		.DEPTH (2 * (2**BW))
	) u_word_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.re    (buf_re),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	bfm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	// hashing, filter memory and result register
	bfm_back #(
		.BIT_COUNT    (BIT_COUNT),
		.HASH_COUNT   (HASH_COUNT),
		.MAX_WORD_LEN (MAX_WORD_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (seed_q),
		.q_empty   (q_empty),
		.q_dout    (q_dout),
		.q_pop     (q_pop),
		.status    (status),
		.buf_re    (buf_re),
		.buf_raddr (buf_raddr),
		.buf_rdata (buf_rdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.present   (present),
		.truncated (truncated),
		.op_done   (op_done)
	);

endmodule
